### design/vmcr_pkg.sv
// ----------------------------------------------------------------------------
// vmcr_pkg: shared types and constants
// Item types, input kinds and register offsets of the virtio-mmio console
// register block.
// ----------------------------------------------------------------------------
package vmcr_pkg;

  localparam int unsigned QUEUE_SIZE_MAX = 256;
  localparam int unsigned QSIZE_W        = 9;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_POLL  = 2'd2;
  localparam logic [1:0] KIND_USED  = 2'd3;

  localparam logic [31:0] MAGIC_VALUE = 32'h7472_6976;
  localparam logic [31:0] VERSION     = 32'd2;
  localparam logic [31:0] DEVICE_ID   = 32'd3;
  localparam logic [31:0] VENDOR_ID   = 32'h554d_4551;

  localparam logic [8:0] OFS_MAGIC        = 9'h000;
  localparam logic [8:0] OFS_VERSION      = 9'h004;
  localparam logic [8:0] OFS_DEVICE_ID    = 9'h008;
  localparam logic [8:0] OFS_VENDOR_ID    = 9'h00c;
  localparam logic [8:0] OFS_DEV_FEAT     = 9'h010;
  localparam logic [8:0] OFS_DEV_FEAT_SEL = 9'h014;
  localparam logic [8:0] OFS_DRV_FEAT     = 9'h020;
  localparam logic [8:0] OFS_DRV_FEAT_SEL = 9'h024;
  localparam logic [8:0] OFS_QUEUE_SEL    = 9'h030;
  localparam logic [8:0] OFS_QUEUE_NUM_MX = 9'h034;
  localparam logic [8:0] OFS_QUEUE_NUM    = 9'h038;
  localparam logic [8:0] OFS_QUEUE_READY  = 9'h044;
  localparam logic [8:0] OFS_QUEUE_NOTIFY = 9'h050;
  localparam logic [8:0] OFS_INT_STATUS   = 9'h060;
  localparam logic [8:0] OFS_INT_ACK      = 9'h064;
  localparam logic [8:0] OFS_STATUS       = 9'h070;
  localparam logic [8:0] OFS_DESC_LO      = 9'h080;
  localparam logic [8:0] OFS_DESC_HI      = 9'h084;
  localparam logic [8:0] OFS_AVAIL_LO     = 9'h090;
  localparam logic [8:0] OFS_AVAIL_HI     = 9'h094;
  localparam logic [8:0] OFS_USED_LO      = 9'h0a0;
  localparam logic [8:0] OFS_USED_HI      = 9'h0a4;

  localparam int unsigned STATUS_DRV_UP_BIT = 2;  // status value 4: driver up
  localparam int unsigned CFG_BYTES         = 12;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  offset;
    logic [3:0]  access_size;
    logic [31:0] write_data;
    logic [15:0] host_cols;
    logic [15:0] host_rows;
    logic        resized;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        irq_level;
    logic        notify_tx;
    logic        notify_rx;
    logic        driver_ready;
    logic        device_reset;
  } out_item_t;

endpackage

### design/virtio_mmio_console_regs.sv
// ----------------------------------------------------------------------------
// virtio_mmio_console_regs: virtio-mmio v2 console register file
// Transport registers for two queues, interrupt status and console geometry.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i / in_ready_o / in_data_i): one item per bus read,
//     bus write, host poll or used-buffer completion.
//   out channel (out_valid_o / out_ready_i / out_data_o): exactly one result
//     item per input item, in order.
//   All work for an item is done in the cycle it is accepted: register state
//   updates at that edge and the result is loaded into the output register,
//   visible the next cycle. An item can be accepted every cycle while the output is not stalled.
//   The output register is the only buffer; while it holds an item that the
//   receiver has not taken, in_ready_o is low. Taking an item and accepting a
//   new one in the same cycle is allowed, so a stall costs no bubbles after it.
//   Notify and device_reset fields are one-item pulses riding in the result.
//   Reset (rst_ni low, async) clears every register but the result payload
//   and empties the output register; the block is ready once reset is released.
// ----------------------------------------------------------------------------
module virtio_mmio_console_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  vmcr_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output vmcr_pkg::out_item_t  out_data_o
);

  localparam int unsigned QW = vmcr_pkg::QSIZE_W;

  logic [31:0] dev_status_q, dev_status_d;
  logic [1:0]  int_status_q, int_status_d;
  logic [31:0] dev_feat_sel_q, dev_feat_sel_d;
  logic [31:0] drv_feat_sel_q, drv_feat_sel_d;
  logic [63:0] drv_features_q, drv_features_d;
  logic [31:0] queue_sel_q, queue_sel_d;
  logic [QW-1:0] queue_size_q [2];
  logic [QW-1:0] queue_size_d [2];
  logic [31:0] queue_ready_q [2];
  logic [31:0] queue_ready_d [2];
  logic [63:0] desc_addr_q [2];
  logic [63:0] desc_addr_d [2];
  logic [63:0] avail_addr_q [2];
  logic [63:0] avail_addr_d [2];
  logic [63:0] used_addr_q [2];
  logic [63:0] used_addr_d [2];
  logic [15:0] geom_cols_q, geom_cols_d;
  logic [15:0] geom_rows_q, geom_rows_d;
  logic        sync_done_q, sync_done_d;

  logic                out_valid_q;
  vmcr_pkg::out_item_t out_data_q, out_data_d;

  logic        in_fire;
  logic        q_ok;
  logic        qi;
  logic        drv_rdy_now;
  logic        sync_now;
  logic        geom_diff;
  logic [63:0] rd_data;
  logic [63:0] cfg_data;
  logic        ntx, nrx, drst;
  logic [31:0] wd;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign wd          = in_data_i.write_data;
  assign q_ok        = (queue_sel_q[31:1] == 31'd0);
  assign qi          = queue_sel_q[0];
  assign drv_rdy_now = dev_status_q[vmcr_pkg::STATUS_DRV_UP_BIT] &&
                       (queue_ready_q[0] != 32'd0);
  assign sync_now    = !sync_done_q && drv_rdy_now;
  assign geom_diff   = (in_data_i.host_cols != geom_cols_q) ||
                       (in_data_i.host_rows != geom_rows_q);

  // Config space: cols, rows, port count 1, emergency write 0; little endian
  always_comb begin
    logic [7:0] cfg [vmcr_pkg::CFG_BYTES];
    logic [3:0] size_c;
    logic [8:0] idx;
    cfg      = '{default: 8'd0};
    cfg[0]   = geom_cols_q[7:0];
    cfg[1]   = geom_cols_q[15:8];
    cfg[2]   = geom_rows_q[7:0];
    cfg[3]   = geom_rows_q[15:8];
    cfg[4]   = 8'd1;
    size_c   = (in_data_i.access_size > 4'd8) ? 4'd8 : in_data_i.access_size;
    cfg_data = '0;
    for (int i = 0; i < 8; i++) begin
      idx = {1'b0, in_data_i.offset[7:0]} + 9'(i);
      if ((4'(i) < size_c) && (idx < 9'(vmcr_pkg::CFG_BYTES))) begin
        cfg_data[i*8 +: 8] = cfg[idx[3:0]];
      end
    end
  end

  always_comb begin
    rd_data = '0;
    if (in_data_i.offset[8]) begin
      rd_data = cfg_data;
    end else begin
      unique case (in_data_i.offset)
        vmcr_pkg::OFS_MAGIC:        rd_data = {32'd0, vmcr_pkg::MAGIC_VALUE};
        vmcr_pkg::OFS_VERSION:      rd_data = {32'd0, vmcr_pkg::VERSION};
        vmcr_pkg::OFS_DEVICE_ID:    rd_data = {32'd0, vmcr_pkg::DEVICE_ID};
        vmcr_pkg::OFS_VENDOR_ID:    rd_data = {32'd0, vmcr_pkg::VENDOR_ID};
        vmcr_pkg::OFS_DEV_FEAT:     rd_data = (dev_feat_sel_q <= 32'd1) ? 64'd1 : 64'd0;
        vmcr_pkg::OFS_QUEUE_NUM_MX: rd_data = q_ok ? 64'(vmcr_pkg::QUEUE_SIZE_MAX) : 64'd0;
        vmcr_pkg::OFS_QUEUE_READY:  rd_data = q_ok ? {32'd0, queue_ready_q[qi]} : 64'd0;
        vmcr_pkg::OFS_INT_STATUS:   rd_data = {62'd0, int_status_q};
        vmcr_pkg::OFS_STATUS:       rd_data = {32'd0, dev_status_q};
        default:                    rd_data = '0;
      endcase
    end
  end

  always_comb begin
    dev_status_d   = dev_status_q;
    int_status_d   = int_status_q;
    dev_feat_sel_d = dev_feat_sel_q;
    drv_feat_sel_d = drv_feat_sel_q;
    drv_features_d = drv_features_q;
    queue_sel_d    = queue_sel_q;
    queue_size_d   = queue_size_q;
    queue_ready_d  = queue_ready_q;
    desc_addr_d    = desc_addr_q;
    avail_addr_d   = avail_addr_q;
    used_addr_d    = used_addr_q;
    geom_cols_d    = geom_cols_q;
    geom_rows_d    = geom_rows_q;
    sync_done_d    = sync_done_q;
    ntx            = 1'b0;
    nrx            = 1'b0;
    drst           = 1'b0;

    if (in_fire) begin
      unique case (in_data_i.kind)
        vmcr_pkg::KIND_READ: begin
        end
        vmcr_pkg::KIND_WRITE: begin
          unique case (in_data_i.offset)
            vmcr_pkg::OFS_DEV_FEAT_SEL: dev_feat_sel_d = wd;
            vmcr_pkg::OFS_DRV_FEAT: begin
              if (drv_feat_sel_q == 32'd0) begin
                drv_features_d[31:0] = wd;
              end else if (drv_feat_sel_q == 32'd1) begin
                drv_features_d[63:32] = wd;
              end
            end
            vmcr_pkg::OFS_DRV_FEAT_SEL: drv_feat_sel_d = wd;
            vmcr_pkg::OFS_QUEUE_SEL:    queue_sel_d = wd;
            vmcr_pkg::OFS_QUEUE_NUM: begin
              if (q_ok) begin
                queue_size_d[qi] = (wd > 32'(vmcr_pkg::QUEUE_SIZE_MAX)) ?
                                   QW'(vmcr_pkg::QUEUE_SIZE_MAX) : wd[QW-1:0];
              end
            end
            vmcr_pkg::OFS_QUEUE_READY: begin
              if (q_ok) queue_ready_d[qi] = wd;
            end
            vmcr_pkg::OFS_QUEUE_NOTIFY: begin
              if (wd == 32'd1) begin
                ntx = 1'b1;
              end else if (wd == 32'd0) begin
                nrx = 1'b1;
                if (sync_now) begin
                  sync_done_d     = 1'b1;
                  geom_cols_d     = in_data_i.host_cols;
                  geom_rows_d     = in_data_i.host_rows;
                  int_status_d[1] = 1'b1;
                end
              end
            end
            vmcr_pkg::OFS_INT_ACK: int_status_d = int_status_q & ~wd[1:0];
            vmcr_pkg::OFS_STATUS: begin
              if (wd == 32'd0) begin
                // full device reset, geometry reloaded from the host
                dev_status_d   = '0;
                int_status_d   = '0;
                dev_feat_sel_d = '0;
                drv_feat_sel_d = '0;
                drv_features_d = '0;
                queue_sel_d    = '0;
                queue_size_d   = '{default: '0};
                queue_ready_d  = '{default: '0};
                desc_addr_d    = '{default: '0};
                avail_addr_d   = '{default: '0};
                used_addr_d    = '{default: '0};
                sync_done_d    = 1'b0;
                geom_cols_d    = in_data_i.host_cols;
                geom_rows_d    = in_data_i.host_rows;
                drst           = 1'b1;
              end else begin
                dev_status_d = wd;
              end
            end
            vmcr_pkg::OFS_DESC_LO:  if (q_ok) desc_addr_d[qi][31:0]   = wd;
            vmcr_pkg::OFS_DESC_HI:  if (q_ok) desc_addr_d[qi][63:32]  = wd;
            vmcr_pkg::OFS_AVAIL_LO: if (q_ok) avail_addr_d[qi][31:0]  = wd;
            vmcr_pkg::OFS_AVAIL_HI: if (q_ok) avail_addr_d[qi][63:32] = wd;
            vmcr_pkg::OFS_USED_LO:  if (q_ok) used_addr_d[qi][31:0]   = wd;
            vmcr_pkg::OFS_USED_HI:  if (q_ok) used_addr_d[qi][63:32]  = wd;
            default: begin
            end
          endcase
        end
        vmcr_pkg::KIND_POLL: begin
          nrx = 1'b1;
          // a fresh sync leaves geometry equal to the host's, so no resize then
          if (sync_now || (in_data_i.resized && geom_diff)) begin
            geom_cols_d     = in_data_i.host_cols;
            geom_rows_d     = in_data_i.host_rows;
            int_status_d[1] = 1'b1;
          end
          if (sync_now) sync_done_d = 1'b1;
        end
        vmcr_pkg::KIND_USED: int_status_d[0] = 1'b1;
        default: begin
        end
      endcase
    end

    out_data_d.read_data    = (in_data_i.kind == vmcr_pkg::KIND_READ) ? rd_data : 64'd0;
    out_data_d.irq_level    = (int_status_d != 2'd0);
    out_data_d.notify_tx    = ntx;
    out_data_d.notify_rx    = nrx;
    out_data_d.driver_ready = dev_status_d[vmcr_pkg::STATUS_DRV_UP_BIT] &&
                              (queue_ready_d[0] != 32'd0);
    out_data_d.device_reset = drst;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_status_q   <= '0;
      int_status_q   <= '0;
      dev_feat_sel_q <= '0;
      drv_feat_sel_q <= '0;
      drv_features_q <= '0;
      queue_sel_q    <= '0;
      queue_size_q   <= '{default: '0};
      queue_ready_q  <= '{default: '0};
      desc_addr_q    <= '{default: '0};
      avail_addr_q   <= '{default: '0};
      used_addr_q    <= '{default: '0};
      geom_cols_q    <= '0;
      geom_rows_q    <= '0;
      sync_done_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      dev_status_q   <= dev_status_d;
      int_status_q   <= int_status_d;
      dev_feat_sel_q <= dev_feat_sel_d;
      drv_feat_sel_q <= drv_feat_sel_d;
      drv_features_q <= drv_features_d;
      queue_sel_q    <= queue_sel_d;
      queue_size_q   <= queue_size_d;
      queue_ready_q  <= queue_ready_d;
      desc_addr_q    <= desc_addr_d;
      avail_addr_q   <= avail_addr_d;
      used_addr_q    <= used_addr_d;
      geom_cols_q    <= geom_cols_d;
      geom_rows_q    <= geom_rows_d;
      sync_done_q    <= sync_done_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded only when an item is accepted
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

endmodule
